// ----- hdl/xcfr_pkg.sv -----
// ---------------------------------------------------------------------------
// xcfr_pkg
// Shared constants, types and the error reply byte table for the XOR
// checked frame receiver.
// ---------------------------------------------------------------------------
package xcfr_pkg;

	localparam logic [7:0] FR_START          = 8'd27;
	localparam logic [7:0] FR_TOKEN          = 8'd14;
	localparam logic [7:0] FR_ANS_CKSUM_ERR  = 8'hb0;
	localparam logic [7:0] FR_STAT_CKSUM_ERR = 8'hc1;
	localparam logic [7:0] REPLY_LEN_HI      = 8'h00;
	localparam logic [7:0] REPLY_LEN_LO      = 8'h02;
	localparam logic [7:0] REPLY_LAST_IDX    = 8'd7;

	// XOR of every fixed byte of the error reply; the sequence number is folded in later
	localparam logic [7:0] REPLY_CK_BASE = FR_START ^ REPLY_LEN_HI ^ REPLY_LEN_LO ^
		FR_TOKEN ^ FR_ANS_CKSUM_ERR ^ FR_STAT_CKSUM_ERR;

	// Run request from the parser to the emitter
	typedef struct packed {
		logic       start;
		logic       err;
		logic [7:0] last_idx;
		logic [7:0] seq;
	} emit_cmd_t;

	function automatic logic [7:0] reply_byte(input logic [2:0] idx, input logic [7:0] seq);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = FR_START;
			3'd1: b = seq;
			3'd2: b = REPLY_LEN_HI;
			3'd3: b = REPLY_LEN_LO;
			3'd4: b = FR_TOKEN;
			3'd5: b = FR_ANS_CKSUM_ERR;
			3'd6: b = FR_STAT_CKSUM_ERR;
			3'd7: b = REPLY_CK_BASE ^ seq;
		endcase
		return b;
	endfunction

endpackage

// ----- hdl/xcfr_ram.sv -----
// ---------------------------------------------------------------------------
// xcfr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ---------------------------------------------------------------------------
module xcfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/xcfr_parser.sv -----
// ---------------------------------------------------------------------------
// xcfr_parser
// Frame header state machine: tracks the running XOR, validates length and
// token, writes payload bytes into the buffer RAM and requests a run at the
// checksum byte.
// ---------------------------------------------------------------------------
module xcfr_parser #(
	parameter int BUF_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [7:0]                   rx_byte,
	output logic                         ram_we,
	output logic [$clog2(BUF_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                   ram_wdata,
	output xcfr_pkg::emit_cmd_t          cmd
);

	import xcfr_pkg::*;

	localparam int AW    = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_START,
		PH_SEQ,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_TOKEN,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	phase_t           phase_q;
	logic [7:0]       seq_q;
	logic [7:0]       len_hi_q;
	logic [CNT_W-1:0] len_q;
	logic [7:0]       check_q;
	logic [CNT_W-1:0] fill_q;

	logic [15:0]      full_len;
	logic [CNT_W-1:0] fill_nxt;
	logic [CNT_W-1:0] fill_m1;
	logic [7:0]       check_nxt;

	assign full_len  = {len_hi_q, rx_byte};
	assign fill_nxt  = fill_q + 1'b1;
	assign fill_m1   = fill_q - 1'b1;
	assign check_nxt = check_q ^ rx_byte;

	assign ram_we    = accept && (phase_q == PH_PAYLOAD);
	assign ram_waddr = fill_q[AW-1:0];
	assign ram_wdata = rx_byte;

	always_comb begin
		cmd.start    = accept && (phase_q == PH_CHECK);
		cmd.err      = (check_nxt != 8'd0);
		cmd.last_idx = cmd.err ? REPLY_LAST_IDX : 8'(fill_m1);
		cmd.seq      = seq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			seq_q    <= 8'd0;
			len_hi_q <= 8'd0;
			len_q    <= '0;
			check_q  <= 8'd0;
			fill_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_SEQ: begin
					check_q <= check_nxt;
					seq_q   <= rx_byte;
					phase_q <= PH_LEN_HI;
				end
				PH_LEN_HI: begin
					check_q  <= check_nxt;
					len_hi_q <= rx_byte;
					phase_q  <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					check_q <= check_nxt;
					len_q   <= full_len[CNT_W-1:0];
					fill_q  <= '0;
					// drop empty or oversized frames
					if (full_len == 16'd0 || full_len > 16'(BUF_DEPTH)) begin
						phase_q <= PH_START;
					end else begin
						phase_q <= PH_TOKEN;
					end
				end
				PH_TOKEN: begin
					if (rx_byte == FR_TOKEN) begin
						check_q <= check_nxt;
						phase_q <= PH_PAYLOAD;
					end else begin
						phase_q <= PH_START;
					end
				end
				PH_PAYLOAD: begin
					check_q <= check_nxt;
					fill_q  <= fill_nxt;
					if (fill_nxt >= len_q) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					check_q <= check_nxt;
					phase_q <= PH_START;
				end
				default: begin
					phase_q <= PH_START;
					if (rx_byte == FR_START) begin
						check_q <= FR_START;
						phase_q <= PH_SEQ;
					end
				end
			endcase
		end
	end

endmodule

// ----- hdl/xcfr_emitter.sv -----
// ---------------------------------------------------------------------------
// xcfr_emitter
// Run sequencer: issues buffer reads (or reply table lookups), holds the
// read result in the RAM output stage and feeds the output register.
// ---------------------------------------------------------------------------
module xcfr_emitter #(
	parameter int BUF_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  xcfr_pkg::emit_cmd_t          cmd,
	output logic                         busy,
	output logic                         ram_re,
	output logic [$clog2(BUF_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                   ram_rdata,
	output logic                         m_valid,
	input  logic                         m_ready,
	output logic                         m_kind,
	output logic [7:0]                   m_byte,
	output logic                         m_last
);

	import xcfr_pkg::*;

	localparam int AW    = $clog2(BUF_DEPTH);
	localparam int IDX_W = (AW > 3) ? AW : 3;

	logic             active_q;
	logic             err_q;
	logic [7:0]       seq_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_idx_q;

	logic             s1_valid_q;
	logic             s1_kind_q;
	logic             s1_last_q;
	logic [7:0]       s1_byte_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;

	logic out_free;
	logic issue;
	logic at_last;

	assign out_free  = !out_valid_q || m_ready;
	assign issue     = active_q && (!s1_valid_q || out_free);
	assign at_last   = (idx_q == last_idx_q);
	assign ram_re    = issue && !err_q;
	assign ram_raddr = idx_q[AW-1:0];
	assign busy      = active_q;

	assign m_valid = out_valid_q;
	assign m_kind  = out_kind_q;
	assign m_byte  = out_byte_q;
	assign m_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				active_q <= 1'b1;
			end else if (issue && at_last) begin
				active_q <= 1'b0;
			end

			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (out_free) begin
				s1_valid_q <= 1'b0;
			end

			if (out_free) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			err_q      <= cmd.err;
			seq_q      <= cmd.seq;
			idx_q      <= '0;
			last_idx_q <= cmd.last_idx[IDX_W-1:0];
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
		end

		if (issue) begin
			s1_kind_q <= err_q;
			s1_last_q <= at_last;
			s1_byte_q <= reply_byte(idx_q[2:0], seq_q);
		end

		if (out_free && s1_valid_q) begin
			out_kind_q <= s1_kind_q;
			out_last_q <= s1_last_q;
			out_byte_q <= s1_kind_q ? s1_byte_q : ram_rdata;
		end
	end

	a_start_when_idle : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !active_q)
		else $error("run requested while a run is still being issued");

	a_stop_after_last : assert property (@(posedge clk) disable iff (!arst_n)
		issue && at_last |=> !active_q)
		else $error("emitter still active after issuing the last item");

	a_reply_ends_on_seven : assert property (@(posedge clk) disable iff (!arst_n)
		issue && err_q && at_last |-> idx_q[2:0] == 3'd7)
		else $error("error reply run not eight bytes long");

endmodule

// ----- hdl/xor_checked_frame_receiver_core.sv -----
// ---------------------------------------------------------------------------
// xor_checked_frame_receiver_core
// Parses framed bytes (start, sequence, length, token, payload, XOR check),
// buffers the payload in RAM and emits it as a run, or an error reply run.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] = rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[7:0] = out_byte, tuser = out_kind,
//                                             tlast = out_last
//
// One input byte per cycle while no run is being issued.
// A run keeps s_axis_tready low until its last result is issued, one read a cycle
// on the payload RAM read port for a payload run while the output does not stall;
// the first result passes the run start flag, the read stage and the output register.
// Output stalls hold the read stage and the output register; no reset pass.
// Reset clears the parser and the emitter control; the RAM is not cleared.
// ---------------------------------------------------------------------------
module xor_checked_frame_receiver_core #(
	parameter int BUF_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tuser,   // [0] out_kind
	output logic       m_axis_tlast
);

	import xcfr_pkg::*;

	localparam int AW = $clog2(BUF_DEPTH);

	logic          accept;
	logic          busy;
	emit_cmd_t     cmd;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign s_axis_tready = !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	xcfr_parser #(.BUF_DEPTH(BUF_DEPTH)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (s_axis_tdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.cmd       (cmd)
	);

	xcfr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	xcfr_emitter #(.BUF_DEPTH(BUF_DEPTH)) u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.busy      (busy),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_kind    (m_axis_tuser),
		.m_byte    (m_axis_tdata),
		.m_last    (m_axis_tlast)
	);

	a_no_rw_overlap : assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("payload write and run read in the same cycle");

	a_no_accept_in_run : assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !accept)
		else $error("input transaction accepted during a run");

endmodule

// ----- tb/sv/tb_xor_checked_frame_receiver_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_xor_checked_frame_receiver_core
// Streams framed bytes into the frame receiver: junk, dropped frames, good
// frames and frames with a bad checksum. Payload runs and error reply runs
// are predicted byte by byte and checked against the output stream, with
// random gaps on the input side and stalls on the output side.
// ---------------------------------------------------------------------------
module tb_xor_checked_frame_receiver_core;
	import xcfr_pkg::*;

	localparam int BUF_DEPTH   = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 16;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SEQ, PH_LEN_HI, PH_LEN_LO, PH_TOKEN, PH_DATA, PH_CHECK
	} rx_phase_t;

	typedef enum int {
		FK_GOOD, FK_BAD_SUM, FK_BAD_TOKEN, FK_BAD_LEN, FK_TRUNCATED, FK_NOISE
	} frame_kind_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} out_beat_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	logic [7:0] rx_backlog[$];
	out_beat_t  awaited_beats[$];
	int         mismatches = 0;
	int         cycles     = 0;

	// predictor state
	rx_phase_t  rx_phase = PH_IDLE;
	logic [7:0] rx_seq   = 8'h00;
	logic [15:0] rx_len  = 16'h0000;
	logic [7:0] rx_xor   = 8'h00;
	logic [7:0] rx_store[BUF_DEPTH];
	int         rx_fill  = 0;

	xor_checked_frame_receiver_core #(.BUF_DEPTH(BUF_DEPTH)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int exp);
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, exp);
		mismatches++;
	endtask

	// Advance the parser by one byte and queue whatever run it releases
	task automatic parse_rx_byte(input logic [7:0] b);
		logic [7:0] reply[8];
		logic [7:0] ck;
		out_beat_t  beat;
		case (rx_phase)
			PH_SEQ: begin
				rx_xor ^= b;
				rx_seq = b;
				rx_phase = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				rx_xor ^= b;
				rx_len = {b, 8'h00};
				rx_phase = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				rx_xor ^= b;
				rx_len[7:0] = b;
				rx_fill = 0;
				rx_phase = (rx_len == 16'd0 || rx_len > BUF_DEPTH) ? PH_IDLE : PH_TOKEN;
			end
			PH_TOKEN: begin
				if (b == FR_TOKEN) begin
					rx_xor ^= b;
					rx_phase = PH_DATA;
				end else begin
					rx_phase = PH_IDLE;
				end
			end
			PH_DATA: begin
				rx_xor ^= b;
				if (rx_fill < BUF_DEPTH) begin
					rx_store[rx_fill] = b;
					rx_fill++;
				end
				if (rx_fill >= rx_len || rx_fill >= BUF_DEPTH)
					rx_phase = PH_CHECK;
			end
			PH_CHECK: begin
				rx_xor ^= b;
				rx_phase = PH_IDLE;
				if (rx_xor != 8'h00) begin
					reply = '{FR_START, rx_seq, REPLY_LEN_HI, REPLY_LEN_LO, FR_TOKEN,
						FR_ANS_CKSUM_ERR, FR_STAT_CKSUM_ERR, 8'h00};
					ck = 8'h00;
					for (int i = 0; i < 7; i++)
						ck ^= reply[i];
					reply[7] = ck;
					for (int i = 0; i < 8; i++) begin
						beat = '{kind: 1'b1, data: reply[i], last: (i == 7)};
						awaited_beats.push_back(beat);
					end
				end else begin
					for (int i = 0; i < rx_fill; i++) begin
						beat = '{kind: 1'b0, data: rx_store[i], last: (i == rx_fill - 1)};
						awaited_beats.push_back(beat);
					end
				end
			end
			default: begin
				rx_phase = PH_IDLE;
				if (b == FR_START) begin
					rx_xor = FR_START;
					rx_phase = PH_SEQ;
				end
			end
		endcase
	endtask

	// Queue the bytes of one frame, whole or spoilt as the kind says
	task automatic queue_frame(input frame_kind_t kind, input logic [15:0] len_field);
		logic [7:0] seq;
		logic [7:0] ck;
		logic [7:0] b;
		int         cut;
		seq = 8'($urandom);
		if (kind == FK_NOISE) begin
			repeat ($urandom_range(1, 4))
				rx_backlog.push_back(8'($urandom));
			return;
		end
		ck = FR_START ^ seq ^ len_field[15:8] ^ len_field[7:0] ^ FR_TOKEN;
		rx_backlog.push_back(FR_START);
		rx_backlog.push_back(seq);
		rx_backlog.push_back(len_field[15:8]);
		rx_backlog.push_back(len_field[7:0]);
		if (kind == FK_BAD_LEN)
			return;
		if (kind == FK_BAD_TOKEN) begin
			do b = 8'($urandom); while (b == FR_TOKEN);
			rx_backlog.push_back(b);
			return;
		end
		rx_backlog.push_back(FR_TOKEN);
		cut = (kind == FK_TRUNCATED) ? $urandom_range(0, len_field - 1) : int'(len_field);
		for (int i = 0; i < cut; i++) begin
			b = 8'($urandom);
			ck ^= b;
			rx_backlog.push_back(b);
		end
		if (kind == FK_TRUNCATED)
			return;
		if (kind == FK_BAD_SUM)
			ck ^= 8'($urandom_range(1, 255));
		rx_backlog.push_back(ck);
	endtask

	// Sender: bursts of random length separated by random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				parse_rx_byte(s_axis_tdata);
			// hold the byte while the transaction is pending
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (rx_backlog.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= rx_backlog.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern is picked anew at random each time the stall tick wraps
	int       stall_mode = 0;
	bit [5:0] stall_tick = 6'd0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			stall_tick <= stall_tick + 6'd1;
			if (stall_tick == 6'd63)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= stall_tick[0];
				2: m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= (stall_tick[3:0] >= 4'd12);
			endcase
		end
	end

	// Output monitor
	always @(posedge clk) begin
		out_beat_t got;
		out_beat_t exp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{kind: m_axis_tuser, data: m_axis_tdata, last: m_axis_tlast};
			if (awaited_beats.size() == 0) begin
				report_mismatch("unexpected transaction", int'(got), 0);
			end else begin
				exp = awaited_beats.pop_front();
				if (got.kind != exp.kind)
					report_mismatch("out_kind", int'(got.kind), int'(exp.kind));
				if (got.data != exp.data)
					report_mismatch("out_byte", int'(got.data), int'(exp.data));
				if (got.last != exp.last)
					report_mismatch("out_last", int'(got.last), int'(exp.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		frame_kind_t kind;
		int          roll;
		int          len;
		logic [15:0] bad_len;

		// outside a frame, zero and oversized lengths
		rx_backlog.push_back(8'h00);
		rx_backlog.push_back(8'hff);
		rx_backlog.push_back(FR_TOKEN);
		queue_frame(FK_BAD_LEN, 16'h0000);
		queue_frame(FK_BAD_LEN, 16'hffff);
		// shortest frame: good, wrong token, bad checksum
		queue_frame(FK_GOOD, 16'd1);
		queue_frame(FK_BAD_TOKEN, 16'd1);
		queue_frame(FK_BAD_SUM, 16'd1);

		// full buffer first, then a mix dominated by good frames
		queue_frame(FK_GOOD, 16'(BUF_DEPTH));
		while (rx_backlog.size() < 120) begin
			roll = $urandom_range(0, 99);
			if (roll < 65)      kind = FK_GOOD;
			else if (roll < 77) kind = FK_BAD_SUM;
			else if (roll < 84) kind = FK_BAD_TOKEN;
			else if (roll < 90) kind = FK_BAD_LEN;
			else if (roll < 95) kind = FK_TRUNCATED;
			else                kind = FK_NOISE;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, BUF_DEPTH) :
				$urandom_range(1, 8);
			if (kind == FK_BAD_LEN) begin
				case ($urandom_range(0, 2))
					0: bad_len = 16'h0000;
					1: bad_len = 16'(BUF_DEPTH + 1);
					default: bad_len = 16'($urandom_range(BUF_DEPTH + 1, 16'hffff));
				endcase
				queue_frame(kind, bad_len);
			end else begin
				queue_frame(kind, 16'(len));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_backlog.size() != 0 || s_axis_tvalid || awaited_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
